/* hw/rtl/lgs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants and types of the life grid stepper.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int GRID_COLS_DEF     = 64;
  localparam int GRID_ROWS_DEF     = 64;
  localparam int HISTORY_DEPTH_DEF = 8;

  localparam int MODE_W   = 2;
  localparam int ADDR_W   = 6;   // width of the cell_col / cell_row fields
  localparam int SIZE_W   = 7;   // active_cols / active_rows registers
  localparam int HLEN_W   = 4;   // history_length register
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int EXT_W    = 9;   // holds any index or size up to 256

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_STEP  = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_WRAP  = 2'd0,
    REG_COLS  = 2'd1,
    REG_ROWS  = 2'd2,
    REG_HLEN  = 2'd3
  } reg_idx_t;

  localparam logic [SIZE_W-1:0] COLS_RESET = 7'd64;
  localparam logic [SIZE_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [HLEN_W-1:0] HLEN_RESET = 4'd1;

  // Life rule constants: birth on three, survival on two or three.
  localparam logic [3:0] BIRTH_CNT   = 4'd3;
  localparam logic [3:0] SURVIVE_CNT = 4'd2;

  // Control handed to every row cell of the ring.
  typedef struct packed {
    logic clear;
    logic shift;
    logic wr_en;
    logic wr_val;
  } cell_ctrl_t;

endpackage : lgs_pkg
`default_nettype wire

/* hw/rtl/lgs_row_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_row_cell
// One grid row of the rotating row ring; takes its neighbor's row on a shift.
// ----------------------------------------------------------------------------
module lgs_row_cell
  import lgs_pkg::*;
#(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int COL_IW    = $clog2(GRID_COLS)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic                 wr_hit,
  input  wire logic [COL_IW-1:0]    wr_col,
  input  wire logic [GRID_COLS-1:0] shift_in,
  output logic      [GRID_COLS-1:0] row_q
);

  logic [GRID_COLS-1:0] row_r, row_nxt;

  always_comb begin
    row_nxt = row_r;
    if (ctrl.clear) begin
      row_nxt = '0;
    end else if (ctrl.shift) begin
      row_nxt = shift_in;
    end else if (ctrl.wr_en && wr_hit) begin
      row_nxt[wr_col] = ctrl.wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q = row_r;

endmodule : lgs_row_cell
`default_nettype wire

/* hw/rtl/lgs_row_update.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_row_update
// Next generation of one row from the rows above, at and below it.
// ----------------------------------------------------------------------------
module lgs_row_update
  import lgs_pkg::*;
#(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int COL_IW    = $clog2(GRID_COLS)
) (
  input  wire logic [GRID_COLS-1:0] above,
  input  wire logic [GRID_COLS-1:0] cur,
  input  wire logic [GRID_COLS-1:0] below,
  input  wire logic [EXT_W-1:0]     eff_cols,
  input  wire logic                 wrap,
  input  wire logic                 one_row,
  input  wire logic                 row_live,
  output logic      [GRID_COLS-1:0] new_row
);

  logic [COL_IW-1:0] last_col;
  logic              one_col;
  logic              skip_v, skip_h, skip_d;
  logic [GRID_COLS-1:0] al, ar, cl, cr, bl, br;

  assign last_col = COL_IW'(eff_cols - EXT_W'(1));
  assign one_col  = (eff_cols == EXT_W'(1));
  assign skip_v   = wrap && one_row;
  assign skip_h   = wrap && one_col;
  assign skip_d   = wrap && one_row && one_col;

  // Left and right neighbor words; wrap inside the active columns.
  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      if (c == 0) begin
        al[c] = wrap & above[last_col];
        cl[c] = wrap & cur[last_col];
        bl[c] = wrap & below[last_col];
      end else begin
        al[c] = above[c-1];
        cl[c] = cur[c-1];
        bl[c] = below[c-1];
      end
      if (EXT_W'(c) == eff_cols - EXT_W'(1) || c == GRID_COLS-1) begin
        ar[c] = wrap & above[0];
        cr[c] = wrap & cur[0];
        br[c] = wrap & below[0];
      end else begin
        ar[c] = above[c+1];
        cr[c] = cur[c+1];
        br[c] = below[c+1];
      end
    end
  end

  always_comb begin
    logic [3:0] n;
    n = '0;
    for (int c = 0; c < GRID_COLS; c++) begin
      n = 4'(!skip_v & above[c]) + 4'(!skip_v & below[c]) +
          4'(!skip_h & cl[c])    + 4'(!skip_h & cr[c]) +
          4'(!skip_d & al[c])    + 4'(!skip_d & ar[c]) +
          4'(!skip_d & bl[c])    + 4'(!skip_d & br[c]);
      new_row[c] = row_live && (EXT_W'(c) < eff_cols) &&
                   ((n == BIRTH_CNT) || ((n == SURVIVE_CNT) && cur[c]));
    end
  end

endmodule : lgs_row_update
`default_nettype wire

/* hw/rtl/lgs_hist_bank.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_hist_bank
// One stored past generation: one row word per address, registered read.
// ----------------------------------------------------------------------------
module lgs_hist_bank
  import lgs_pkg::*;
#(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int ROW_IW    = $clog2(GRID_ROWS)
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ROW_IW-1:0]    wr_addr,
  input  wire logic [GRID_COLS-1:0] wr_data,
  input  wire logic [ROW_IW-1:0]    rd_addr,
  output logic      [GRID_COLS-1:0] rd_data
);

  logic [GRID_COLS-1:0] mem [GRID_ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : lgs_hist_bank
`default_nettype wire

/* hw/rtl/life_grid_stepper_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_grid_stepper_top
// Game of life grid (B3/S23) with history ring and stasis detection.
// ----------------------------------------------------------------------------
// Usage:
//   An input transaction (in_valid high, in_stall low) carries a mode: write
//   one cell, clear the grid, step one generation or read one cell. Each
//   transaction yields exactly one result transaction on the out_ channel
//   with cell_alive, grid_empty and still_evolving.
//   The grid lives in a ring of GRID_ROWS row cells. Every item rotates the
//   ring once around to compare each row with the stored past
//   generations; a step rotates it twice: the first lap copies the grid
//   into the history ring, the second computes and writes back new rows.
//   The next item is taken once the result has been delivered, in the
//   following cycle at the earliest. The row ring rotates one row per cycle.
//   in_stall is high while an item is in flight or its result waits.
//   While out_stall is high the result holds on the out_ ports.
//   Reset (rst_n low at a clock edge) kills every cell, marks all history
//   slots empty and loads the register defaults; no clearing pass is needed.
//   Configure only while idle. Writing history_length empties the history.
// ----------------------------------------------------------------------------
module life_grid_stepper_top
  import lgs_pkg::*;
#(
  parameter int GRID_COLS     = GRID_COLS_DEF,
  parameter int GRID_ROWS     = GRID_ROWS_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [MODE_W-1:0]  in_mode,
  input  wire logic [ADDR_W-1:0]  in_cell_col,
  input  wire logic [ADDR_W-1:0]  in_cell_row,
  input  wire logic               in_cell_value,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_cell_alive,
  output logic                    out_grid_empty,
  output logic                    out_still_evolving,
  // configuration port
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [PADDR_W-1:0] cfg_paddr,
  input  wire logic [PDATA_W-1:0] cfg_pwdata,
  output logic      [PDATA_W-1:0] cfg_prdata,
  output logic                    cfg_pready
);

  localparam int COL_IW = $clog2(GRID_COLS);
  localparam int ROW_IW = $clog2(GRID_ROWS);
  localparam int HS_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_COPY  = 4'b0010,   // lap one of a step: fill a history slot
    ST_SWEEP = 4'b0100,   // compare lap, computes new rows on a step
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // ---------------- configuration registers ----------------
  logic              wrap_r;
  logic [SIZE_W-1:0] cols_r, rows_r;
  logic [HLEN_W-1:0] hlen_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= 1'b0;
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
      hlen_r <= HLEN_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WRAP: wrap_r <= cfg_pwdata[0];
        REG_COLS: cols_r <= cfg_pwdata[SIZE_W-1:0];
        REG_ROWS: rows_r <= cfg_pwdata[SIZE_W-1:0];
        REG_HLEN: hlen_r <= cfg_pwdata[HLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WRAP: cfg_prdata = PDATA_W'(wrap_r);
      REG_COLS: cfg_prdata = PDATA_W'(cols_r);
      REG_ROWS: cfg_prdata = PDATA_W'(rows_r);
      REG_HLEN: cfg_prdata = PDATA_W'(hlen_r);
      default:  cfg_prdata = '0;
    endcase
  end

  // Clamp the active size and history length into their legal ranges.
  logic [EXT_W-1:0] eff_cols, eff_rows, eff_hist;

  always_comb begin
    eff_cols = EXT_W'(cols_r);
    if (eff_cols == '0) eff_cols = EXT_W'(1);
    if (eff_cols > EXT_W'(GRID_COLS)) eff_cols = EXT_W'(GRID_COLS);
    eff_rows = EXT_W'(rows_r);
    if (eff_rows == '0) eff_rows = EXT_W'(1);
    if (eff_rows > EXT_W'(GRID_ROWS)) eff_rows = EXT_W'(GRID_ROWS);
    eff_hist = EXT_W'(hlen_r);
    if (eff_hist == '0) eff_hist = EXT_W'(1);
    if (eff_hist > EXT_W'(HISTORY_DEPTH)) eff_hist = EXT_W'(HISTORY_DEPTH);
  end

  // ---------------- item capture ----------------
  logic             in_acc;
  logic [EXT_W-1:0] in_col_ext, in_row_ext;
  mode_t            mode_r;
  logic [EXT_W-1:0] col_r, row_r;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign in_col_ext = EXT_W'(in_cell_col);
  assign in_row_ext = EXT_W'(in_cell_row);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= mode_t'(in_mode);
      col_r  <= in_col_ext;
      row_r  <= in_row_ext;
    end
  end

  // ---------------- lap counter and state ----------------
  logic [ROW_IW-1:0] cnt_r, cnt_nxt;
  logic              lap_end;
  logic              is_step;

  assign lap_end = (cnt_r == ROW_IW'(GRID_ROWS-1));
  assign is_step = (mode_r == MODE_STEP);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          state_nxt = (mode_t'(in_mode) == MODE_STEP) ? ST_COPY : ST_SWEEP;
        end
      end
      ST_COPY: begin
        cnt_nxt = lap_end ? '0 : cnt_r + ROW_IW'(1);
        if (lap_end) state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        cnt_nxt = lap_end ? '0 : cnt_r + ROW_IW'(1);
        if (lap_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cnt_nxt = '0;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // ---------------- row ring ----------------
  logic [GRID_COLS-1:0] ring_q [GRID_ROWS];
  logic [GRID_COLS-1:0] head, tail_in, new_row;
  cell_ctrl_t           cctrl;
  logic                 wr_ok;

  assign head  = ring_q[0];
  // Drop writes that fall outside the active area.
  assign wr_ok = (in_col_ext < eff_cols) && (in_row_ext < eff_rows);

  always_comb begin
    cctrl.clear  = in_acc && (mode_t'(in_mode) == MODE_CLEAR);
    cctrl.shift  = (state_r == ST_COPY) || (state_r == ST_SWEEP);
    cctrl.wr_en  = in_acc && (mode_t'(in_mode) == MODE_WRITE) && wr_ok;
    cctrl.wr_val = in_cell_value;
  end

  // Rotate the head back in at the tail, or the freshly computed row.
  assign tail_in = ((state_r == ST_SWEEP) && is_step) ? new_row : head;

  for (genvar i = 0; i < GRID_ROWS; i++) begin : g_ring
    lgs_row_cell #(
      .GRID_COLS (GRID_COLS),
      .COL_IW    (COL_IW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cctrl),
      .wr_hit   (in_row_ext == EXT_W'(i)),
      .wr_col   (COL_IW'(in_col_ext)),
      .shift_in ((i == GRID_ROWS-1) ? tail_in : ring_q[(i+1) % GRID_ROWS]),
      .row_q    (ring_q[i])
    );
  end

  // ---------------- line buffers and row update ----------------
  logic [GRID_COLS-1:0] prev_r, first_r, last_r;
  logic [GRID_COLS-1:0] above, below, old_row0;
  logic [EXT_W-1:0]     cnt_ext;
  logic                 row_first, row_last;

  assign cnt_ext   = EXT_W'(cnt_r);
  assign row_first = (cnt_r == '0);
  assign row_last  = (cnt_ext == eff_rows - EXT_W'(1));

  always_ff @(posedge clk) begin
    // Hold the old last active row for the wrap above row zero.
    if (state_r == ST_COPY && row_last) last_r <= head;
    if (state_r == ST_SWEEP) begin
      prev_r <= head;
      if (row_first) first_r <= head;
    end
  end

  assign old_row0 = row_first ? head : first_r;
  assign above    = row_first ? (wrap_r ? last_r : '0) : prev_r;
  assign below    = row_last ? (wrap_r ? old_row0 : '0) : ring_q[1];

  lgs_row_update #(
    .GRID_COLS (GRID_COLS),
    .COL_IW    (COL_IW)
  ) u_update (
    .above    (above),
    .cur      (head),
    .below    (below),
    .eff_cols (eff_cols),
    .wrap     (wrap_r),
    .one_row  (eff_rows == EXT_W'(1)),
    .row_live (cnt_ext < eff_rows),
    .new_row  (new_row)
  );

  // ---------------- history ring ----------------
  logic [HS_W-1:0]      hslot_r, wslot;
  logic [EXT_W-1:0]     wslot_ext, wslot_inc;
  logic [HISTORY_DEPTH-1:0] hvalid_r;
  logic [GRID_COLS-1:0] hist_rd [HISTORY_DEPTH];

  assign wslot_ext = (EXT_W'(hslot_r) < eff_hist) ? EXT_W'(hslot_r) : '0;
  assign wslot     = HS_W'(wslot_ext);
  assign wslot_inc = wslot_ext + EXT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hslot_r  <= '0;
      hvalid_r <= '0;
    end else if (cfg_wr && cfg_idx == REG_HLEN) begin
      hslot_r  <= '0;
      hvalid_r <= '0;
    end else if (state_r == ST_COPY && lap_end) begin
      hvalid_r[wslot] <= 1'b1;
      hslot_r <= (wslot_inc == eff_hist) ? '0 : HS_W'(wslot_inc);
    end
  end

  for (genvar s = 0; s < HISTORY_DEPTH; s++) begin : g_hist
    lgs_hist_bank #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS),
      .ROW_IW    (ROW_IW)
    ) u_bank (
      .clk     (clk),
      .wr_en   ((state_r == ST_COPY) && (wslot == HS_W'(s))),
      .wr_addr (cnt_r),
      .wr_data (head),
      .rd_addr (cnt_nxt),
      .rd_data (hist_rd[s])
    );
  end

  // ---------------- compare lap ----------------
  logic [GRID_COLS-1:0]     cmp_row;
  logic [HISTORY_DEPTH-1:0] match_r, match_row, hist_used;
  logic                     empty_r, alive_r;
  logic                     read_hit;

  assign cmp_row = is_step ? new_row : head;

  always_comb begin
    for (int s = 0; s < HISTORY_DEPTH; s++) begin
      // An empty slot holds a dead grid.
      match_row[s] = (cmp_row == (hvalid_r[s] ? hist_rd[s] : '0));
      hist_used[s] = (EXT_W'(s) < eff_hist);
    end
  end

  assign read_hit = (mode_r == MODE_READ) && (cnt_ext == row_r) &&
                    (row_r < EXT_W'(GRID_ROWS)) && (col_r < EXT_W'(GRID_COLS));

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      match_r <= '1;
      empty_r <= 1'b1;
      alive_r <= 1'b0;
    end else if (state_r == ST_SWEEP) begin
      match_r <= match_r & match_row;
      empty_r <= empty_r & (cmp_row == '0);
      if (read_hit) alive_r <= head[COL_IW'(col_r)];
    end
  end

  // ---------------- result register ----------------
  logic out_alive_r, out_empty_r, out_evol_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_SWEEP && lap_end) begin
      out_alive_r <= read_hit ? head[COL_IW'(col_r)] : alive_r;
      out_empty_r <= empty_r & (cmp_row == '0);
      out_evol_r  <= ~|(match_r & match_row & hist_used);
    end
  end

  assign out_valid          = (state_r == ST_DONE);
  assign out_cell_alive     = out_alive_r;
  assign out_grid_empty     = out_empty_r;
  assign out_still_evolving = out_evol_r;

endmodule : life_grid_stepper_top
`default_nettype wire
